### rtl/lookahead_pd_heading_controller_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lookahead PD heading controller
// Shared wrappers for the concurrent checks at the top level.
// ----------------------------------------------------------------------------
`ifndef LOOKAHEAD_PD_HEADING_CONTROLLER_DEFINES_SVH
`define LOOKAHEAD_PD_HEADING_CONTROLLER_DEFINES_SVH

// Check that holds outside reset.
`define LPDH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds in every cycle, reset included.
`define LPDH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lpdh_pkg.sv
// ----------------------------------------------------------------------------
// lpdh_pkg
// Types, codes and fixed constants of the lookahead PD heading controller.
// ----------------------------------------------------------------------------
package lpdh_pkg;

  localparam int IN_W   = 80;
  localparam int OUT_W  = 32;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 31;
  localparam int CRW    = 44;   // CORDIC vector width
  localparam int ZW     = 20;   // CORDIC angle width, 2^-16 rad

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_APPEND  = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam logic [CFG_AW-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DERIV_GAIN = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_TURN   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DRIVE      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LOOKAHEAD  = 3'd4;

  localparam logic [15:0] PROP_GAIN_RST  = 16'd8192;
  localparam logic [15:0] DERIV_GAIN_RST = 16'd2048;
  localparam logic [14:0] MAX_TURN_RST   = 15'd4096;
  localparam logic [14:0] DRIVE_RST      = 15'd1229;
  localparam logic [30:0] LOOKAHEAD_RST  = 31'd13107;

  localparam logic signed [17:0]   PI_Q13      = 18'sd25736;
  localparam logic signed [17:0]   TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [17:0]   TURN_LIMIT  = 18'sd6430;
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [4:0]           ITER_LAST   = 5'd16;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:    atan_lut = 20'sd51472;
      5'd1:    atan_lut = 20'sd30386;
      5'd2:    atan_lut = 20'sd16055;
      5'd3:    atan_lut = 20'sd8150;
      5'd4:    atan_lut = 20'sd4091;
      5'd5:    atan_lut = 20'sd2047;
      5'd6:    atan_lut = 20'sd1024;
      5'd7:    atan_lut = 20'sd512;
      5'd8:    atan_lut = 20'sd256;
      5'd9:    atan_lut = 20'sd128;
      5'd10:   atan_lut = 20'sd64;
      5'd11:   atan_lut = 20'sd32;
      5'd12:   atan_lut = 20'sd16;
      5'd13:   atan_lut = 20'sd8;
      5'd14:   atan_lut = 20'sd4;
      5'd15:   atan_lut = 20'sd2;
      5'd16:   atan_lut = 20'sd1;
      default: atan_lut = 20'sd0;
    endcase
  endfunction

  typedef enum logic [4:0] {
    S_IDLE, S_N_RD, S_N_DIF, S_N_SQX, S_N_SQY, S_N_CMP,
    S_W_INIT, S_W_RD0, S_W_LD0, S_W_RD, S_W_DIF, S_W_SQX, S_W_SQY,
    S_W_SQRT, S_W_WAIT, S_W_ACC,
    S_T_RD, S_T_DIF, S_C_ROT, S_C_NORM, S_C_ITER, S_E_ERR,
    S_P_MUL1, S_P_MUL2, S_P_SUM, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_RD_IDX, OP_DIF_Q, OP_SQX, OP_SQY, OP_N_CMP,
    OP_W_INIT, OP_LD_PREV, OP_RD_NEXT, OP_DIF_W, OP_SQRT_GO, OP_W_ACC,
    OP_RD_TGT, OP_T_DIF, OP_C_ROT, OP_C_NORM, OP_C_ITER, OP_ERR,
    OP_TURN, OP_MUL1, OP_MUL2, OP_PSUM, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mem_rd;
  } cmd_t;

  typedef struct packed {
    logic query;
    logic empty;
    logic last_pt;
    logic walk_ok;
    logic reached;
    logic walk_more;
    logic sqrt_done;
    logic zero_vec;
    logic norm_done;
    logic iter_last;
    logic big_err;
    logic out_free;
  } stat_t;

endpackage

### rtl/lookahead_pd_heading_controller.sv
// ----------------------------------------------------------------------------
// lookahead_pd_heading_controller
// Carrot-following PD heading controller over a stored fixed-point path.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser selects the item kind (clear path, append point,
//   pose query); in_tdata carries x, y (Q16.16) and heading (Q2.13).
//   Clear and append are taken and give no result. A query gives one
//   result on the output stream: linear and angular speed in out_tdata,
//   the empty-path flag in out_tuser.
//   A query searches all N stored points for the nearest, walks the path
//   segment by segment toward the lookahead distance, normalizes and rotates
//   the CORDIC vector for the bearing, then forms the PD term. Points are
//   read one at a time from the single memory port; each segment waits on
//   the 33-step square-root unit. An empty path goes straight to the result.
//   One item is worked at a time; the next is taken once the result is in
//   the output register, even while the receiver still holds it off.
//   A stalled receiver holds the result and, if a second result is ready,
//   the block waits in its final state.
//   Reset empties the path, clears the kept error and loads the default
//   gains, limits and lookahead distance. Configuration writes apply at once.
// ----------------------------------------------------------------------------
`include "lookahead_pd_heading_controller_defines.svh"

module lookahead_pd_heading_controller import lpdh_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,    // pos_x[31:0], pos_y[63:32], heading[79:64]
  input  logic [1:0]        in_tuser,    // mode[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,   // linear_speed[14:0], angular_speed[30:15], pad
  output logic              out_tuser,   // path_empty[0]
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: one command per cycle toward the datapath
  lpdh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // datapath: path memory, search, walk, bearing, PD and output register
  lpdh_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // path updates and ignored codes are done by the next cycle
  `LPDH_ASSERT(a_short_items, (in_tvalid && in_tready && in_tuser != MODE_QUERY) |=> in_tready, "non-query item did not return to idle")
  // a result is loaded only into a free output register
  `LPDH_ASSERT(a_emit_free, (cmd.op == OP_EMIT) |-> (!out_tvalid || out_tready), "result overwrote a pending transfer")
  // an empty-path result carries zero commands
  `LPDH_ASSERT(a_empty_zero, (out_tvalid && out_tuser) |-> (out_tdata == '0), "empty-path result with nonzero speeds")

endmodule

### rtl/lpdh_sqrt.sv
// ----------------------------------------------------------------------------
// lpdh_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module lpdh_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [64:0] radicand,
  output logic [32:0] root,
  output logic        done
);

  logic [65:0] rad_r;
  logic [35:0] rem_r;
  logic [32:0] root_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [35:0] rem_t, trial;

  assign rem_t = {rem_r[33:0], rad_r[65:64]};
  assign trial = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'd33;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {1'b0, radicand};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[63:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r  <= rem_t - trial;
        root_r <= {root_r[31:0], 1'b1};
      end else begin
        rem_r  <= rem_t;
        root_r <= {root_r[31:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

### rtl/lpdh_ctrl.sv
// ----------------------------------------------------------------------------
// lpdh_ctrl
// Sequencer: steps the datapath through search, walk, bearing and PD term.
// ----------------------------------------------------------------------------
module lpdh_ctrl import lpdh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  stat_t stat,
  output logic  in_tready,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && stat.query) begin
          state_nxt = stat.empty ? S_DONE : S_N_RD;
        end
      end
      S_N_RD:   state_nxt = S_N_DIF;
      S_N_DIF:  state_nxt = S_N_SQX;
      S_N_SQX:  state_nxt = S_N_SQY;
      S_N_SQY:  state_nxt = S_N_CMP;
      S_N_CMP:  state_nxt = stat.last_pt ? S_W_INIT : S_N_RD;
      S_W_INIT: state_nxt = stat.walk_ok ? S_W_RD0 : S_T_RD;
      S_W_RD0:  state_nxt = S_W_LD0;
      S_W_LD0:  state_nxt = S_W_RD;
      S_W_RD:   state_nxt = S_W_DIF;
      S_W_DIF:  state_nxt = S_W_SQX;
      S_W_SQX:  state_nxt = S_W_SQY;
      S_W_SQY:  state_nxt = S_W_SQRT;
      S_W_SQRT: state_nxt = S_W_WAIT;
      S_W_WAIT: state_nxt = stat.sqrt_done ? S_W_ACC : S_W_WAIT;
      S_W_ACC: begin
        if (stat.reached || !stat.walk_more) begin
          state_nxt = S_T_RD;
        end else begin
          state_nxt = S_W_RD;
        end
      end
      S_T_RD:   state_nxt = S_T_DIF;
      S_T_DIF:  state_nxt = S_C_ROT;
      S_C_ROT:  state_nxt = stat.zero_vec ? S_E_ERR : S_C_NORM;
      S_C_NORM: state_nxt = stat.norm_done ? S_C_ITER : S_C_NORM;
      S_C_ITER: state_nxt = stat.iter_last ? S_E_ERR : S_C_ITER;
      S_E_ERR:  state_nxt = S_P_MUL1;
      S_P_MUL1: state_nxt = stat.big_err ? S_DONE : S_P_MUL2;
      S_P_MUL2: state_nxt = S_P_SUM;
      S_P_SUM:  state_nxt = S_DONE;
      S_DONE:   state_nxt = stat.out_free ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.mem_rd = 1'b0;
    in_tready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_ACCEPT;
      end
      S_N_RD, S_W_RD0: begin
        cmd.op     = OP_RD_IDX;
        cmd.mem_rd = 1'b1;
      end
      S_N_DIF:  cmd.op = OP_DIF_Q;
      S_N_SQX, S_W_SQX: cmd.op = OP_SQX;
      S_N_SQY, S_W_SQY: cmd.op = OP_SQY;
      S_N_CMP:  cmd.op = OP_N_CMP;
      S_W_INIT: cmd.op = OP_W_INIT;
      S_W_LD0:  cmd.op = OP_LD_PREV;
      S_W_RD: begin
        cmd.op     = OP_RD_NEXT;
        cmd.mem_rd = 1'b1;
      end
      S_W_DIF:  cmd.op = OP_DIF_W;
      S_W_SQRT: cmd.op = OP_SQRT_GO;
      S_W_ACC:  cmd.op = OP_W_ACC;
      S_T_RD: begin
        cmd.op     = OP_RD_TGT;
        cmd.mem_rd = 1'b1;
      end
      S_T_DIF:  cmd.op = OP_T_DIF;
      S_C_ROT:  cmd.op = OP_C_ROT;
      S_C_NORM: cmd.op = OP_C_NORM;
      S_C_ITER: cmd.op = OP_C_ITER;
      S_E_ERR:  cmd.op = OP_ERR;
      S_P_MUL1: cmd.op = stat.big_err ? OP_TURN : OP_MUL1;
      S_P_MUL2: cmd.op = OP_MUL2;
      S_P_SUM:  cmd.op = OP_PSUM;
      S_DONE:   cmd.op = stat.out_free ? OP_EMIT : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

### rtl/lpdh_dp.sv
// ----------------------------------------------------------------------------
// lpdh_dp
// Datapath: path memory, distance squares, segment sums, CORDIC, PD term.
// ----------------------------------------------------------------------------
module lpdh_dp import lpdh_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tuser,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int SUMW = CNTW + 33;

  function automatic logic [31:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    logic [32:0] m;
    d = 33'(a) - 33'(b);
    m = d[32] ? 33'(-d) : 33'(d);
    absdiff = m[31:0];
  endfunction

  function automatic logic big40(input logic signed [CRW-1:0] v);
    logic [CRW-1:0] m;
    m = v[CRW-1] ? CRW'(-v) : CRW'(v);
    big40 = (m >= (CRW'(1) << 40));
  endfunction

  // configuration
  logic [15:0] pg_r, dg_r;
  logic [14:0] mx_r, ds_r;
  logic [30:0] la_r;

  // path storage
  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [CNTW-1:0] cnt_r;
  logic signed [31:0] rd_x_r, rd_y_r;
  logic [AW-1:0] rd_addr;

  // item and working registers
  logic signed [31:0] px_r, py_r, prev_x_r, prev_y_r;
  logic signed [15:0] hd_r, last_err_r;
  logic               empty_r;
  logic [AW-1:0]      idx_r, best_idx_r, tgt_r;
  logic [31:0]        da_r, db_r;
  logic [63:0]        sq_r, prod;
  logic [64:0]        dist_r, best_r;
  logic [SUMW-1:0]    sum_r, sum_nxt;
  logic signed [CRW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0]  z_r, zr_w;
  logic [4:0]         it_r;
  logic signed [17:0] err_r, e0_w, e_w;
  logic signed [16:0] bear_w;
  logic signed [18:0] ed_w;
  logic signed [35:0] m1_r, m2_r, m1_w, m2_w;
  logic signed [36:0] acc_w, sh_w, mx_w;
  logic [14:0]        lin_r, out_lin_r;
  logic signed [15:0] ang_r, out_ang_r;
  logic               out_emp_r, out_valid_r;
  logic signed [32:0] tdx_w, tdy_w;

  logic [32:0] root;
  logic        sqrt_done;

  lpdh_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_SQRT_GO),
    .radicand (dist_r),
    .root     (root),
    .done     (sqrt_done)
  );

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_r <= PROP_GAIN_RST;
      dg_r <= DERIV_GAIN_RST;
      mx_r <= MAX_TURN_RST;
      ds_r <= DRIVE_RST;
      la_r <= LOOKAHEAD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PROP_GAIN:  pg_r <= cfg_wdata[15:0];
        REG_DERIV_GAIN: dg_r <= cfg_wdata[15:0];
        REG_MAX_TURN:   mx_r <= cfg_wdata[14:0];
        REG_DRIVE:      ds_r <= cfg_wdata[14:0];
        REG_LOOKAHEAD:  la_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      last_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_ACCEPT) begin
        case (in_tuser)
          MODE_CLEAR:  cnt_r <= '0;
          MODE_APPEND: if (cnt_r < CNTW'(MAX_POINTS)) cnt_r <= cnt_r + CNTW'(1);
          default: ;
        endcase
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
        if (!empty_r) last_err_r <= err_r[15:0];
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memory: one write port, one registered read port
  always_comb begin
    case (cmd.op)
      OP_RD_NEXT: rd_addr = idx_r + AW'(1);
      OP_RD_TGT:  rd_addr = tgt_r;
      default:    rd_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT && in_tuser == MODE_APPEND && cnt_r < CNTW'(MAX_POINTS)) begin
      mem_x[cnt_r[AW-1:0]] <= in_tdata[31:0];
      mem_y[cnt_r[AW-1:0]] <= in_tdata[63:32];
    end
    if (cmd.mem_rd) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  // arithmetic
  assign prod    = (cmd.op == OP_SQX ? da_r : db_r) * (cmd.op == OP_SQX ? da_r : db_r);
  assign sum_nxt = sum_r + SUMW'(root);
  assign tdx_w   = 33'(rd_x_r) - 33'(px_r);
  assign tdy_w   = 33'(rd_y_r) - 33'(py_r);
  assign zr_w    = z_r + 20'sd4;
  assign bear_w  = zr_w[ZW-1:3];
  assign e0_w    = 18'(bear_w) - 18'(hd_r);
  assign ed_w    = 19'(err_r) - 19'(last_err_r);
  assign m1_w    = $signed({1'b0, pg_r}) * err_r;
  assign m2_w    = $signed({1'b0, dg_r}) * ed_w;
  assign acc_w   = 37'(m1_r) + 37'(m2_r) + 37'sd4096;
  assign sh_w    = acc_w >>> 13;
  assign mx_w    = $signed({22'b0, mx_r});

  always_comb begin
    if (e0_w > PI_Q13) begin
      e_w = e0_w - TWO_PI_Q13;
    end else if (e0_w < -PI_Q13) begin
      e_w = e0_w + TWO_PI_Q13;
    end else begin
      e_w = e0_w;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        px_r    <= in_tdata[31:0];
        py_r    <= in_tdata[63:32];
        hd_r    <= in_tdata[79:64];
        empty_r <= (cnt_r == '0);
        idx_r   <= '0;
      end
      OP_DIF_Q: begin
        da_r <= absdiff(rd_x_r, px_r);
        db_r <= absdiff(rd_y_r, py_r);
      end
      OP_SQX: sq_r <= prod;
      OP_SQY: dist_r <= {1'b0, sq_r} + {1'b0, prod};
      OP_N_CMP: begin
        if (idx_r == '0 || dist_r < best_r) begin
          best_r     <= dist_r;
          best_idx_r <= idx_r;
        end
        idx_r <= idx_r + AW'(1);
      end
      OP_W_INIT: begin
        idx_r <= best_idx_r;
        sum_r <= '0;
        tgt_r <= AW'(cnt_r - CNTW'(1));
      end
      OP_LD_PREV: begin
        prev_x_r <= rd_x_r;
        prev_y_r <= rd_y_r;
      end
      OP_DIF_W: begin
        da_r     <= absdiff(rd_x_r, prev_x_r);
        db_r     <= absdiff(rd_y_r, prev_y_r);
        prev_x_r <= rd_x_r;
        prev_y_r <= rd_y_r;
      end
      OP_W_ACC: begin
        sum_r <= sum_nxt;
        if (sum_nxt >= SUMW'(la_r)) begin
          tgt_r <= idx_r + AW'(1);
        end else begin
          idx_r <= idx_r + AW'(1);
        end
      end
      OP_T_DIF: begin
        cx_r <= CRW'(tdx_w);
        cy_r <= CRW'(tdy_w);
      end
      OP_C_ROT: begin
        it_r <= '0;
        if (cx_r < 0) begin
          if (cy_r >= 0) begin
            cx_r <= cy_r;
            cy_r <= -cx_r;
            z_r  <= HALF_PI_Q16;
          end else begin
            cx_r <= -cy_r;
            cy_r <= cx_r;
            z_r  <= -HALF_PI_Q16;
          end
        end else begin
          z_r <= '0;
        end
      end
      OP_C_NORM: begin
        if (!(big40(cx_r) || big40(cy_r))) begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end
      end
      OP_C_ITER: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + (cy_r >>> it_r);
          cy_r <= cy_r - (cx_r >>> it_r);
          z_r  <= z_r + atan_lut(it_r);
        end else begin
          cx_r <= cx_r - (cy_r >>> it_r);
          cy_r <= cy_r + (cx_r >>> it_r);
          z_r  <= z_r - atan_lut(it_r);
        end
        it_r <= it_r + 5'd1;
      end
      OP_ERR: err_r <= e_w;
      OP_TURN: begin
        lin_r <= '0;
        ang_r <= (err_r > 0) ? $signed({1'b0, mx_r}) : -$signed({1'b0, mx_r});
      end
      OP_MUL1: m1_r <= m1_w;
      OP_MUL2: m2_r <= m2_w;
      OP_PSUM: begin
        lin_r <= ds_r;
        if (sh_w > mx_w) begin
          ang_r <= mx_w[15:0];
        end else if (sh_w < -mx_w) begin
          ang_r <= 16'(-mx_w);
        end else begin
          ang_r <= sh_w[15:0];
        end
      end
      OP_EMIT: begin
        out_lin_r <= empty_r ? '0 : lin_r;
        out_ang_r <= empty_r ? '0 : ang_r;
        out_emp_r <= empty_r;
      end
      default: ;
    endcase
  end

  // status toward the sequencer
  always_comb begin
    stat.query     = (in_tuser == MODE_QUERY);
    stat.empty     = (cnt_r == '0);
    stat.last_pt   = (CNTW'(idx_r) + CNTW'(1) == cnt_r);
    stat.walk_ok   = (CNTW'(best_idx_r) + CNTW'(1) < cnt_r);
    stat.reached   = (sum_nxt >= SUMW'(la_r));
    stat.walk_more = ((CNTW+1)'(idx_r) + (CNTW+1)'(2) < (CNTW+1)'(cnt_r));
    stat.sqrt_done = sqrt_done;
    stat.zero_vec  = (cx_r == '0) && (cy_r == '0);
    stat.norm_done = big40(cx_r) || big40(cy_r);
    stat.iter_last = (it_r == ITER_LAST);
    stat.big_err   = (err_r > TURN_LIMIT) || (err_r < -TURN_LIMIT);
    stat.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ang_r, out_lin_r};
  assign out_tuser  = out_emp_r;

endmodule

### sim/lpdh_checker.sv
// ----------------------------------------------------------------------------
// lpdh_checker
// Watches the input, result and configuration ports of the heading
// controller, predicts every query result and compares it field by field.
// ----------------------------------------------------------------------------
module lpdh_checker import lpdh_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,
  input  logic              out_tuser,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                pending,
  output int                fail_count
);

  typedef struct {
    logic [14:0] lin;
    logic [15:0] ang;
    logic        empty;
  } cmd_result_t;

  cmd_result_t cmd_q[$];

  logic signed [31:0] pt_x [MAX_POINTS];
  logic signed [31:0] pt_y [MAX_POINTS];
  int                 n_pts;
  longint             prev_err;
  logic [15:0]        kp, kd;
  logic [14:0]        turn_max, fwd_speed;
  logic [30:0]        look_dist;

  function automatic logic [67:0] dist2(longint dx, longint dy);
    logic [67:0] mx, my;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    return mx * mx + my * my;
  endfunction

  function automatic logic [67:0] isqrt(logic [67:0] v);
    logic [67:0] r, c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (68'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // CORDIC vectoring, angle in 2^-16 rad, rounded to Q2.13
  function automatic longint heading_to(longint x, longint y);
    longint z, t, xs, ys;
    longint atan_q16 [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2, 1};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 102944;
      end else begin
        x = -y; y = t; z = -102944;
      end
    end
    while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 17; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_q16[i];
      end else begin
        x -= ys; y += xs; z -= atan_q16[i];
      end
    end
    return (z + 4) >>> 3;
  endfunction

  function automatic cmd_result_t steer(longint rx, longint ry, longint hd);
    cmd_result_t r;
    logic [67:0] best_d, d, walked;
    int          best, tgt;
    longint      err, acc, ang, mx;
    mx = turn_max;
    if (n_pts == 0) begin
      r.lin = '0; r.ang = '0; r.empty = 1'b1;
      return r;
    end
    best = 0;
    best_d = '0;
    for (int i = 0; i < n_pts; i++) begin
      d = dist2(longint'(pt_x[i]) - rx, longint'(pt_y[i]) - ry);
      if (i == 0 || d < best_d) begin
        best_d = d; best = i;
      end
    end
    tgt = n_pts - 1;
    walked = '0;
    for (int i = best; i + 1 < n_pts; i++) begin
      walked += isqrt(dist2(longint'(pt_x[i+1]) - pt_x[i], longint'(pt_y[i+1]) - pt_y[i]));
      if (walked >= look_dist) begin
        tgt = i + 1;
        break;
      end
    end
    err = heading_to(longint'(pt_x[tgt]) - rx, longint'(pt_y[tgt]) - ry) - hd;
    if (err > 25736) err -= 51472;
    if (err < -25736) err += 51472;
    if (err > 6430 || err < -6430) begin
      r.lin = '0;
      ang = (err > 0) ? mx : -mx;
    end else begin
      acc = longint'(kp) * err + longint'(kd) * (err - prev_err);
      ang = (acc + 4096) >>> 13;
      if (ang > mx) ang = mx;
      if (ang < -mx) ang = -mx;
      r.lin = fwd_speed;
    end
    r.ang = ang[15:0];
    r.empty = 1'b0;
    prev_err = err;
    return r;
  endfunction

  always @(posedge clk) begin
    cmd_result_t exp_r;
    if (!rst_n) begin
      cmd_q.delete();
      n_pts     <= 0;
      prev_err  = 0;
      kp        <= PROP_GAIN_RST;
      kd        <= DERIV_GAIN_RST;
      turn_max  <= MAX_TURN_RST;
      fwd_speed <= DRIVE_RST;
      look_dist <= LOOKAHEAD_RST;
      pending   <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PROP_GAIN:  kp        <= cfg_wdata[15:0];
          REG_DERIV_GAIN: kd        <= cfg_wdata[15:0];
          REG_MAX_TURN:   turn_max  <= cfg_wdata[14:0];
          REG_DRIVE:      fwd_speed <= cfg_wdata[14:0];
          REG_LOOKAHEAD:  look_dist <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          MODE_CLEAR: n_pts <= 0;
          MODE_APPEND:
            if (n_pts < MAX_POINTS) begin
              pt_x[n_pts] <= in_tdata[31:0];
              pt_y[n_pts] <= in_tdata[63:32];
              n_pts <= n_pts + 1;
            end
          MODE_QUERY:
            cmd_q.push_back(steer(longint'($signed(in_tdata[31:0])),
                                  longint'($signed(in_tdata[63:32])),
                                  longint'($signed(in_tdata[79:64]))));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (cmd_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected transfer: tdata=%h tuser=%b", out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = cmd_q.pop_front();
          if (out_tdata[14:0] !== exp_r.lin || out_tdata[30:15] !== exp_r.ang ||
              out_tuser !== exp_r.empty) begin
            if (fail_count < 10)
              $display("mismatch: exp lin=%0d ang=%0d empty=%b, got lin=%0d ang=%0d empty=%b",
                       exp_r.lin, $signed(exp_r.ang), exp_r.empty, out_tdata[14:0],
                       $signed(out_tdata[30:15]), out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= cmd_q.size();
    end
  end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives path loads, pose queries and register writes into the heading
// controller with random stalls on both streams; the checker predicts and
// compares every command, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import lpdh_pkg::*;

  localparam int  N_ITEMS = 580;
  localparam longint LIMIT = 40000000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;    // pos_x[31:0], pos_y[63:32], heading[79:64]
  logic [1:0]        in_tuser;    // mode[1:0]
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;   // linear_speed[14:0], angular_speed[30:15], pad
  logic              out_tuser;   // path_empty[0]
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  int     pending, fail_count;
  int     sent;
  bit     quiet;
  int     sink_hold;
  longint cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lookahead_pd_heading_controller u_dut (.*);

  lpdh_checker u_chk (.*);

  // Watchdog: a hang or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver side: random ready bursts, always ready near the end.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_hold  <= 0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 2) != 0);
      sink_hold  <= $urandom_range(1, 16);
    end
  end

  // Offer one item and hold it until the transfer happens.
  task automatic push_item(logic [1:0] mode, logic [31:0] x, logic [31:0] y,
                           logic [15:0] hd);
    bit ok;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {hd, y, x};
    // Sample ready mid-cycle so the accepting edge is known without a race.
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    sent++;
  endtask

  function automatic logic [15:0] rand_heading();
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  // Drain: wait for every command and let the block settle before writes.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write all registers plus an unused index; style picks extremes or random.
  task automatic load_regs(int style);
    logic [CFG_DW-1:0] v [6];
    logic [CFG_AW-1:0] a [6];
    a = '{REG_PROP_GAIN, REG_DERIV_GAIN, REG_MAX_TURN, REG_DRIVE, REG_LOOKAHEAD,
          CFG_AW'(5 + $urandom_range(0, 2))};
    case (style)
      0: v = '{31'd65535, 31'd65535, 31'd32767, 31'd32767, 31'h7fffffff, 31'h7fffffff};
      1: v = '{31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0};
      default: v = '{31'($urandom_range(0, 65535)), 31'($urandom_range(0, 65535)),
                     31'($urandom_range(0, 32767)), 31'($urandom_range(0, 32767)),
                     31'($urandom_range(0, 400000)), 31'($urandom)};
    endcase
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= a[i];
      cfg_wdata <= v[i] | 31'($urandom) & {31{style == 0}};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // One well-formed run: clear, a path of nearby points, then queries.
  task automatic path_run();
    int          n_app, n_qry;
    logic [31:0] px, py;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 2)       n_app = $urandom_range(250, 262);   // fill near or past capacity
    else if (r < 8)  n_app = 0;
    else             n_app = $urandom_range(1, 10);
    if (n_app > N_ITEMS - sent) n_app = N_ITEMS - sent;
    n_qry = $urandom_range(1, 6);
    px = $urandom;
    py = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      px = 32'($signed($urandom_range(0, 524288)) - 262144);
      py = 32'($signed($urandom_range(0, 524288)) - 262144);
    end
    push_item(MODE_CLEAR, $urandom, $urandom, 16'($urandom));
    for (int i = 0; i < n_app; i++) begin
      push_item(MODE_APPEND, px, py, 16'($urandom));
      px += 32'($signed($urandom_range(0, 40000)) - 20000);
      py += 32'($signed($urandom_range(0, 40000)) - 20000);
    end
    for (int i = 0; i < n_qry; i++)
      push_item(MODE_QUERY, px + 32'($signed($urandom_range(0, 200000)) - 100000),
                py + 32'($signed($urandom_range(0, 200000)) - 100000), rand_heading());
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= MODE_CLEAR;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    quiet     = 1'b0;
    sent      = 0;
    cycles    <= 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty path, robot on the target, coordinate extremes,
    // the ignored mode, headings at both ends.
    push_item(MODE_QUERY, 32'h7fffffff, 32'h80000000, 16'sd25736);
    push_item(MODE_APPEND, 32'd0, 32'd0, 16'h0);
    push_item(MODE_QUERY, 32'd0, 32'd0, 16'sd25736);
    push_item(MODE_QUERY, 32'd0, 32'd0, -16'sd25736);
    push_item(MODE_APPEND, 32'h7fffffff, 32'h80000000, 16'hffff);
    push_item(MODE_APPEND, 32'h80000000, 32'h7fffffff, 16'h0);
    push_item(MODE_QUERY, 32'h80000000, 32'h80000000, -16'sd25736);
    push_item(MODE_QUERY, 32'h7fffffff, 32'h7fffffff, 16'sd0);
    push_item(MODE_IGNORED, 32'hffffffff, 32'hffffffff, 16'hffff);
    push_item(MODE_QUERY, 32'h00010000, 32'hffff0000, 16'sd6430);
    push_item(MODE_CLEAR, 32'd0, 32'd0, 16'h0);
    push_item(MODE_QUERY, 32'd5, 32'd5, 16'sd100);
    push_item(MODE_APPEND, 32'h00010000, 32'd0, 16'h0);
    push_item(MODE_APPEND, 32'h00020000, 32'h00010000, 16'h0);
    push_item(MODE_QUERY, 32'd0, 32'd0, 16'sd0);
    push_item(MODE_QUERY, 32'd0, 32'd0, 16'sd12000);
    push_item(MODE_QUERY, 32'd0, 32'd0, -16'sd12000);
    drain();
    load_regs(0);
    push_item(MODE_QUERY, 32'd0, 32'd0, 16'sd1000);
    push_item(MODE_QUERY, 32'd0, 32'd0, -16'sd1000);
    drain();
    load_regs(1);
    push_item(MODE_QUERY, 32'd0, 32'd0, 16'sd1000);
    push_item(MODE_QUERY, 32'd0, 32'd0, -16'sd20000);

    // Random part: mostly path runs, some noise, register phases between.
    for (int phase = 0; sent < N_ITEMS; phase++) begin
      drain();
      load_regs(phase % 5 == 0 ? 0 : (phase % 5 == 1 ? 1 : 2));
      for (int k = 0; k < 4 && sent < N_ITEMS; k++) begin
        if (sent > N_ITEMS - 60) quiet = 1'b1;
        if ($urandom_range(0, 4) != 0)
          path_run();
        else
          push_item(2'($urandom_range(0, 3)), $urandom, $urandom, rand_heading());
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lpdh_pkg.sv
rtl/lpdh_sqrt.sv
rtl/lpdh_ctrl.sv
rtl/lpdh_dp.sv
rtl/lookahead_pd_heading_controller.sv
sim/lpdh_checker.sv
sim/tb.sv
